/* sv/mpq_pkg.sv */
package mpq_pkg;

    localparam int VALUE_W = 32;
    localparam int OCC_W   = 5;

    localparam logic OP_INSERT  = 1'b0;
    localparam logic OP_EXTRACT = 1'b1;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_OVERFLOW = 2'd1;
    localparam logic [1:0] ST_EMPTY    = 2'd2;

    typedef struct packed {
        logic                       operation;
        logic signed [VALUE_W-1:0]  value;
    } mpq_in_t;

    typedef struct packed {
        logic [1:0]                 status;
        logic signed [VALUE_W-1:0]  max_value;
        logic [OCC_W-1:0]           occupancy;
    } mpq_out_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_SCAN,
        S_SHIFT,
        S_FINISH
    } mpq_state_t;

    typedef struct packed {
        logic       take;
        logic       set_status;
        logic [1:0] status_code;
        logic       ins_write;
        logic       scan_start;
        logic       scan_step;
        logic       scan_end;
        logic       shift_step;
        logic       dec_fill;
        logic       out_load;
    } mpq_cmd_t;

    typedef struct packed {
        logic op_extract;
        logic full;
        logic empty;
        logic scan_last;
        logic need_shift;
        logic shift_last;
    } mpq_sts_t;

endpackage

/* sv/mpq_ram.sv */
module mpq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* sv/mpq_ctrl.sv */
module mpq_ctrl
    import mpq_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    output logic     m_valid,
    input  logic     m_ready,
    input  mpq_sts_t sts,
    output mpq_cmd_t cmd
);

    mpq_state_t state_reg, state_next;
    logic       m_valid_reg, m_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                if (sts.op_extract && !sts.empty) begin
                    state_next = S_SCAN;
                end else begin
                    state_next = S_FINISH;
                end
            end
            S_SCAN: begin
                if (sts.scan_last) begin
                    state_next = sts.need_shift ? S_SHIFT : S_FINISH;
                end
            end
            S_SHIFT: begin
                if (sts.shift_last) begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_ready  = 1'b1;
                cmd.take = s_valid;
            end
            S_DECODE: begin
                if (!sts.op_extract) begin
                    if (sts.full) begin
                        cmd.set_status  = 1'b1;
                        cmd.status_code = ST_OVERFLOW;
                    end else begin
                        cmd.ins_write = 1'b1;
                    end
                end else if (sts.empty) begin
                    cmd.set_status  = 1'b1;
                    cmd.status_code = ST_EMPTY;
                end else begin
                    cmd.scan_start = 1'b1;
                end
            end
            S_SCAN: begin
                cmd.scan_step = 1'b1;
                if (sts.scan_last) begin
                    cmd.scan_end = 1'b1;
                    cmd.dec_fill = !sts.need_shift;
                end
            end
            S_SHIFT: begin
                cmd.shift_step = 1'b1;
                cmd.dec_fill   = sts.shift_last;
            end
            S_FINISH: begin
                cmd.out_load = !m_valid_reg || m_ready;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

    always_comb begin
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

/* sv/mpq_dp.sv */
module mpq_dp
    import mpq_pkg::*;
#(
    parameter int CAPACITY = 16
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  mpq_in_t  s_data,
    input  mpq_cmd_t cmd,
    output mpq_sts_t sts,
    output mpq_out_t m_data
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = CW + 1;

    logic [CW-1:0]              fill_reg, fill_next;
    logic                       op_reg;
    logic signed [VALUE_W-1:0]  value_reg;
    logic [1:0]                 status_reg;
    logic signed [VALUE_W-1:0]  max_reg;
    logic signed [VALUE_W-1:0]  best_reg;
    logic [AW-1:0]              pos_reg;
    logic [AW-1:0]              cmp_idx_reg;
    logic [AW-1:0]              sh_idx_reg;
    mpq_out_t                   out_reg;

    logic                       ram_we;
    logic [AW-1:0]              ram_waddr;
    logic [VALUE_W-1:0]         ram_wdata;
    logic [AW-1:0]              ram_raddr;
    logic [VALUE_W-1:0]         ram_rdata;

    logic signed [VALUE_W-1:0]  best_next;
    logic [AW-1:0]              pos_next;
    logic [XW-1:0]              fill_x;

    mpq_ram #(
        .WIDTH(VALUE_W),
        .DEPTH(CAPACITY)
    ) u_ram (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    assign fill_x = XW'(fill_reg);

    // running maximum, oldest wins on ties
    always_comb begin
        if (cmp_idx_reg == '0 || $signed(ram_rdata) > best_reg) begin
            best_next = $signed(ram_rdata);
            pos_next  = cmp_idx_reg;
        end else begin
            best_next = best_reg;
            pos_next  = pos_reg;
        end
    end

    always_comb begin
        sts.op_extract = (op_reg == OP_EXTRACT);
        sts.full       = (fill_x >= XW'(CAPACITY));
        sts.empty      = (fill_reg == '0);
        sts.scan_last  = (XW'(cmp_idx_reg) + XW'(1) == fill_x);
        sts.need_shift = (XW'(pos_next) + XW'(1) < fill_x);
        sts.shift_last = (XW'(sh_idx_reg) + XW'(2) >= fill_x);
    end

    always_comb begin
        ram_we    = cmd.ins_write || cmd.shift_step;
        ram_waddr = cmd.ins_write ? fill_reg[AW-1:0] : sh_idx_reg;
        ram_wdata = cmd.ins_write ? value_reg : ram_rdata;
        priority if (cmd.scan_start) begin
            ram_raddr = '0;
        end else if (cmd.scan_end) begin
            ram_raddr = AW'(XW'(pos_next) + XW'(1));
        end else if (cmd.scan_step) begin
            ram_raddr = AW'(XW'(cmp_idx_reg) + XW'(1));
        end else if (cmd.shift_step) begin
            ram_raddr = AW'(XW'(sh_idx_reg) + XW'(2));
        end else begin
            ram_raddr = '0;
        end
    end

    always_comb begin
        fill_next = fill_reg;
        if (cmd.ins_write) begin
            fill_next = CW'(fill_x + XW'(1));
        end else if (cmd.dec_fill) begin
            fill_next = CW'(fill_x - XW'(1));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg <= '0;
        end else begin
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.take) begin
            op_reg     <= s_data.operation;
            value_reg  <= s_data.value;
            status_reg <= ST_OK;
            max_reg    <= '0;
        end
        if (cmd.set_status) begin
            status_reg <= cmd.status_code;
        end
        if (cmd.scan_start) begin
            cmp_idx_reg <= '0;
        end
        if (cmd.scan_step) begin
            best_reg    <= best_next;
            pos_reg     <= pos_next;
            cmp_idx_reg <= AW'(XW'(cmp_idx_reg) + XW'(1));
        end
        if (cmd.scan_end) begin
            max_reg    <= best_next;
            sh_idx_reg <= pos_next;
        end
        if (cmd.shift_step) begin
            sh_idx_reg <= AW'(XW'(sh_idx_reg) + XW'(1));
        end
        if (cmd.out_load) begin
            out_reg.status    <= status_reg;
            out_reg.max_value <= max_reg;
            out_reg.occupancy <= OCC_W'(fill_reg);
        end
    end

    assign m_data = out_reg;

endmodule

/* sv/max_priority_queue_scan_extract.sv */
// channel   ports                               payload
// input     s_valid, s_ready, s_data            mpq_in_t  (operation, value)
// result    m_valid, m_ready, m_data            mpq_out_t (status, max_value, occupancy)
//
// insert and empty or full cases pass through the decode and finish states from accept to result
// extract scans all stored entries for the maximum, then shifts the entries above it down
// by one: one entry per cycle through the single read port of the entry memory
// aresetn is synchronous and clears the fill count and the handshake state only
// a new item is accepted while an earlier result still waits in the output register
module max_priority_queue_scan_extract
    import mpq_pkg::*;
#(
    parameter int CAPACITY = 16
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  mpq_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output mpq_out_t m_data
);

    mpq_cmd_t cmd;
    mpq_sts_t sts;

    mpq_ctrl u_ctrl (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .sts    (sts),
        .cmd    (cmd)
    );

    mpq_dp #(
        .CAPACITY(CAPACITY)
    ) u_dp (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_data (s_data),
        .cmd    (cmd),
        .sts    (sts),
        .m_data (m_data)
    );

endmodule
